// ===== hw/rtl/block_pool_allocator_top_assert.svh =====
// Assertion macros used by the block pool allocator controller.
`ifndef BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("block pool allocator assertion failed");
`define BPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("block pool allocator assertion failed");
`define BPA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("block pool allocator assertion failed");
`else
`define BPA_ASSERT_ALWAYS(lbl, expr)
`define BPA_ASSERT_IMP(lbl, ante, cons)
`define BPA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/bpa_pkg.sv =====
// Types, constants and command structs of the block pool allocator.
package bpa_pkg;

    localparam int SLOT_W         = 6;
    localparam int COUNT_W        = 7;
    localparam int POOL_SLOTS_DEF = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        logic               status;
        logic [COUNT_W-1:0] slots_free;
    } t_out_item;

    typedef struct packed {
        logic init;
        logic accept;
        logic step_a;
        logic step_b;
        logic step_c;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic quick;
    } t_status;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-port RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bpa_ctrl.sv =====
// Controller state machine of the block pool allocator.
`include "block_pool_allocator_top_assert.svh"
module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bpa_pkg::t_status i_status,
    output bpa_pkg::t_cmd    o_cmd
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_STEP_A,
        ST_STEP_B,
        ST_STEP_C,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_INIT: begin
                cmd.init = 1'b1;
                if (i_status.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = i_status.quick ? ST_RESP : ST_STEP_A;
                end
            end
            ST_STEP_A: begin
                cmd.step_a = 1'b1;
                n_state    = ST_STEP_B;
            end
            ST_STEP_B: begin
                cmd.step_b = 1'b1;
                n_state    = ST_STEP_C;
            end
            ST_STEP_C: begin
                cmd.step_c = 1'b1;
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `BPA_ASSERT_ALWAYS(a_one_step, $onehot0({cmd.init, cmd.step_a, cmd.step_b, cmd.step_c}))
    `BPA_ASSERT_IMP(a_load_room, cmd.load_out, !r_out_valid || i_out_ready)
    `BPA_ASSERT_IMP(a_full_walk, cmd.accept && !i_status.quick, ##3 cmd.step_c)
    `BPA_ASSERT_NXT(a_one_at_a_time, cmd.accept, !o_in_ready)

endmodule

// ===== hw/rtl/bpa_datapath.sv =====
// Datapath of the block pool allocator: list heads, free count and link memories.
module bpa_datapath #(
    parameter int POOL_SLOTS = bpa_pkg::POOL_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpa_pkg::t_cmd     i_cmd,
    input  bpa_pkg::t_in_item i_in_data,
    output bpa_pkg::t_status  o_status,
    output bpa_pkg::t_out_item o_out_data
);
    import bpa_pkg::*;

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;
    localparam logic [LW-1:0] LinkNone = LW'(POOL_SLOTS);

    function automatic logic is_slot(input logic [LW-1:0] v);
        return v < LinkNone;
    endfunction

    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_taken_head, n_taken_head;
    logic [LW-1:0] r_count, n_count;
    logic [SW-1:0] r_init_idx;
    logic [SW-1:0] r_s;
    logic          r_op;
    logic          r_exh;
    t_out_item     r_out;

    logic          next_we, prev_we, ram_re;
    logic [SW-1:0] next_addr, prev_addr;
    logic [LW-1:0] next_wdata, prev_wdata;
    logic [LW-1:0] next_rdata, prev_rdata;
    logic [SW-1:0] acc_s;
    logic          in_range;
    logic [LW-1:0] s_link;

    assign in_range = CW'(i_in_data.slot_index) < CW'(POOL_SLOTS);
    assign acc_s    = (i_in_data.op == OP_FREE) ? SW'(i_in_data.slot_index)
                                                : r_free_head[SW-1:0];
    assign s_link   = LW'(r_s);

    assign o_status.init_last = (r_init_idx == SW'(POOL_SLOTS - 1));
    assign o_status.quick     = (i_in_data.op == OP_FREE) ? !in_range
                                                          : !is_slot(r_free_head);

    always_comb begin
        next_we      = 1'b0;
        prev_we      = 1'b0;
        ram_re       = 1'b0;
        next_addr    = r_s;
        prev_addr    = r_s;
        next_wdata   = '0;
        prev_wdata   = '0;
        n_free_head  = r_free_head;
        n_taken_head = r_taken_head;
        n_count      = r_count;
        if (i_cmd.init) begin
            next_we    = 1'b1;
            prev_we    = 1'b1;
            next_addr  = r_init_idx;
            prev_addr  = r_init_idx;
            next_wdata = (r_init_idx == '0) ? LinkNone : LW'(r_init_idx) - LW'(1);
            prev_wdata = LW'(r_init_idx) + LW'(1);
        end else if (i_cmd.accept) begin
            ram_re    = 1'b1;
            next_addr = acc_s;
            prev_addr = acc_s;
        end else if (i_cmd.step_a) begin
            if (r_op == OP_ALLOC) begin
                next_we    = 1'b1;
                next_wdata = r_taken_head;
                if (is_slot(next_rdata)) begin
                    prev_we    = 1'b1;
                    prev_addr  = next_rdata[SW-1:0];
                    prev_wdata = LinkNone;
                end
                n_free_head = next_rdata;
                if (r_count != '0) begin
                    n_count = r_count - LW'(1);
                end
            end else begin
                if (is_slot(prev_rdata)) begin
                    next_we    = 1'b1;
                    next_addr  = prev_rdata[SW-1:0];
                    next_wdata = next_rdata;
                end else if (r_taken_head == s_link) begin
                    n_taken_head = next_rdata;
                end
                if (is_slot(next_rdata)) begin
                    prev_we    = 1'b1;
                    prev_addr  = next_rdata[SW-1:0];
                    prev_wdata = prev_rdata;
                end
                if (r_count < LinkNone) begin
                    n_count = r_count + LW'(1);
                end
            end
        end else if (i_cmd.step_b) begin
            if (r_op == OP_ALLOC) begin
                if (is_slot(r_taken_head)) begin
                    prev_we    = 1'b1;
                    prev_addr  = r_taken_head[SW-1:0];
                    prev_wdata = s_link;
                end
                n_taken_head = s_link;
            end else begin
                next_we    = 1'b1;
                next_wdata = r_free_head;
                if (is_slot(r_free_head)) begin
                    prev_we    = 1'b1;
                    prev_addr  = r_free_head[SW-1:0];
                    prev_wdata = s_link;
                end
                n_free_head = s_link;
            end
        end else if (i_cmd.step_c) begin
            prev_we    = 1'b1;
            prev_wdata = LinkNone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= LW'(POOL_SLOTS - 1);
            r_taken_head <= LinkNone;
            r_count      <= LinkNone;
            r_init_idx   <= '0;
        end else begin
            r_free_head  <= n_free_head;
            r_taken_head <= n_taken_head;
            r_count      <= n_count;
            if (i_cmd.init) begin
                r_init_idx <= r_init_idx + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_s   <= acc_s;
            r_op  <= i_in_data.op;
            r_exh <= (i_in_data.op == OP_ALLOC) && !is_slot(r_free_head);
        end
        if (i_cmd.load_out) begin
            r_out.granted_slot <= (r_op == OP_ALLOC && !r_exh) ? SLOT_W'(r_s) : '0;
            r_out.status       <= r_exh;
            r_out.slots_free   <= COUNT_W'(r_count);
        end
    end

    assign o_out_data = r_out;

    bpa_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_re    (ram_re),
        .i_addr  (next_addr),
        .i_wdata (next_wdata),
        .o_rdata (next_rdata)
    );

    bpa_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_SLOTS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_re    (ram_re),
        .i_addr  (prev_addr),
        .i_wdata (prev_wdata),
        .o_rdata (prev_rdata)
    );

endmodule

// ===== hw/rtl/block_pool_allocator_top.sv =====
// Top level of the block pool allocator.
// The input channel (i_in_valid, o_in_ready, i_in_data) takes one request item:
// op selects allocate or free, and slot_index names the slot to free.
// The output channel (o_out_valid, i_out_ready, o_out_data) returns one item per
// request with the granted slot, the status and the free count after the request.
// A normal allocate or free reads the links when it is accepted; then steps A, B
// and C write the single-port next and prev link memories, and step C loads the
// output register if it is free. Otherwise the result is loaded once it is free.
// An allocate on an exhausted pool or a free of an out-of-range slot skips the steps.
// One request is worked on at a time: no item is accepted until the result of the
// one before has been loaded into the output register.
// After reset a clearing pass writes the initial links of every slot; no item is
// accepted until it is done. All slots then start free, highest index at the head.
// The result waits in the output register while the receiver stalls. A new item
// is still accepted, and its result waits until the register is taken.
module block_pool_allocator_top #(
    parameter int POOL_SLOTS = bpa_pkg::POOL_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpa_pkg::t_out_item o_out_data
);
    import bpa_pkg::*;

    t_cmd    cmd;
    t_status status;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bpa_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

// ===== verif/block_pool_allocator_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the block pool allocator: directed and random requests.
module block_pool_allocator_top_test;

    import bpa_pkg::*;

    localparam int                 SLOTS        = POOL_SLOTS_DEF;
    localparam logic [COUNT_W-1:0] SLOT_NONE    = COUNT_W'(SLOTS);
    localparam logic               ST_OK        = 1'b0;
    localparam logic               ST_EXHAUSTED = 1'b1;
    localparam int                 DIR_ROWS     = 17;
    localparam int                 PHASES       = 6;

    typedef struct packed {
        logic               op;
        logic [SLOT_W-1:0]  slot;
        logic               typed;
        logic [SLOT_W-1:0]  want_slot;
        logic               want_status;
        logic [COUNT_W-1:0] want_free;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    logic [COUNT_W-1:0] pool_next [SLOTS];
    logic [COUNT_W-1:0] pool_prev [SLOTS];
    logic [COUNT_W-1:0] free_top;
    logic [COUNT_W-1:0] taken_top;
    logic [COUNT_W-1:0] free_total;

    t_out_item result_q [$];
    int        error_count = 0;
    bit        calm = 1'b0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_ALLOC, 6'd0,  1'b1, 6'd63, ST_OK, 7'd63},
        '{OP_FREE,  6'd63, 1'b1, 6'd0,  ST_OK, 7'd64},
        '{OP_FREE,  6'd0,  1'b1, 6'd0,  ST_OK, 7'd64},
        '{OP_ALLOC, 6'd63, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd0,  1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd42, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd21, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd62, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd61, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd0,  1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd0,  1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd42, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd21, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd0,  1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd63, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_FREE,  6'd63, 1'b0, 6'd0,  ST_OK, 7'd0},
        '{OP_ALLOC, 6'd0,  1'b0, 6'd0,  ST_OK, 7'd0}
    };

    int phase_alloc_pct [PHASES] = '{100, 0, 50, 90, 10, 50};
    int phase_noise_pct [PHASES] = '{0, 0, 0, 0, 5, 40};
    int phase_items     [PHASES] = '{72, 72, 90, 80, 60, 70};

    block_pool_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic pool_clear();
        for (int i = 0; i < SLOTS; i++) begin
            pool_next[i] = (i == 0) ? SLOT_NONE : COUNT_W'(i - 1);
            pool_prev[i] = COUNT_W'(i + 1);
        end
        free_top   = COUNT_W'(SLOTS - 1);
        taken_top  = SLOT_NONE;
        free_total = COUNT_W'(SLOTS);
    endtask

    function automatic t_out_item pool_apply(input t_in_item req);
        t_out_item          res;
        logic [COUNT_W-1:0] s;
        logic [COUNT_W-1:0] p;
        logic [COUNT_W-1:0] n;
        res = '0;
        if (req.op == OP_ALLOC) begin
            s = free_top;
            if (s >= SLOT_NONE) begin
                res.status = ST_EXHAUSTED;
            end else begin
                free_top = pool_next[s];
                if (free_top < SLOT_NONE) pool_prev[free_top] = SLOT_NONE;
                pool_next[s] = taken_top;
                if (taken_top < SLOT_NONE) pool_prev[taken_top] = s;
                pool_prev[s] = SLOT_NONE;
                taken_top = s;
                if (free_total > 0) free_total = free_total - COUNT_W'(1);
                res.granted_slot = s[SLOT_W-1:0];
            end
        end else if (int'(req.slot_index) < SLOTS) begin
            s = {1'b0, req.slot_index};
            p = pool_prev[s];
            n = pool_next[s];
            if (p < SLOT_NONE) begin
                pool_next[p] = n;
            end else if (taken_top == s) begin
                taken_top = n;
            end
            if (n < SLOT_NONE) pool_prev[n] = p;
            pool_next[s] = free_top;
            if (free_top < SLOT_NONE) pool_prev[free_top] = s;
            pool_prev[s] = SLOT_NONE;
            free_top = s;
            if (free_total < SLOT_NONE) free_total = free_total + COUNT_W'(1);
        end
        res.slots_free = free_total;
        return res;
    endfunction

    task automatic issue_request(input t_in_item req, input logic typed, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        predicted = pool_apply(req);
        result_q.push_back(typed ? want : predicted);
    endtask

    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", out_data));
            end else begin
                want = result_q.pop_front();
                if (out_data.granted_slot !== want.granted_slot)
                    report_mismatch($sformatf("granted_slot %0d, expected %0d",
                        out_data.granted_slot, want.granted_slot));
                if (out_data.status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                        out_data.status, want.status));
                if (out_data.slots_free !== want.slots_free)
                    report_mismatch($sformatf("slots_free %0d, expected %0d",
                        out_data.slots_free, want.slots_free));
            end
        end
    end

    initial begin
        t_in_item           req;
        t_out_item          want;
        logic [SLOT_W-1:0]  owned [$];
        logic [COUNT_W-1:0] walk;
        int                 steps;
        pool_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            req.op             = dir_rows[r].op;
            req.slot_index     = dir_rows[r].slot;
            want.granted_slot  = dir_rows[r].want_slot;
            want.status        = dir_rows[r].want_status;
            want.slots_free    = dir_rows[r].want_free;
            issue_request(req, dir_rows[r].typed, want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 2);
            for (int k = 0; k < phase_items[ph]; k++) begin
                req.slot_index = SLOT_W'($urandom_range(0, SLOTS - 1));
                if ($urandom_range(1, 100) <= phase_noise_pct[ph]) begin
                    req.op = $urandom_range(0, 1) ? OP_FREE : OP_ALLOC;
                end else begin
                    owned.delete();
                    walk  = taken_top;
                    steps = 0;
                    while (walk < SLOT_NONE && steps < SLOTS) begin
                        owned.push_back(walk[SLOT_W-1:0]);
                        walk = pool_next[walk];
                        steps++;
                    end
                    if (owned.size() == 0 || $urandom_range(1, 100) <= phase_alloc_pct[ph]) begin
                        req.op = OP_ALLOC;
                    end else begin
                        req.op         = OP_FREE;
                        req.slot_index = owned[$urandom_range(0, owned.size() - 1)];
                    end
                end
                issue_request(req, 1'b0, '0);
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (result_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== block_pool_allocator_top.f =====
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_datapath.sv
hw/rtl/block_pool_allocator_top.sv
verif/block_pool_allocator_top_test.sv
